>>> hw/rtl/tpsi_pkg.sv
// Shared types and codes for the tour pair-swap improvement block.
// Payload structs, command and register codes, queue entry and back-end states.
// No dependencies.
package tpsi_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  from_town;
        logic [5:0]  to_town;
        logic [15:0] distance;
        logic [5:0]  tour_position;
        logic [5:0]  town;
        logic [15:0] random_fraction;
    } t_in;

    typedef struct packed {
        logic [5:0] position;
        logic [5:0] town_res;
        logic       mutated;
        logic       last;
    } t_out;

    localparam logic [1:0] CMD_LOAD_DIST = 2'd0;
    localparam logic [1:0] CMD_LOAD_TOUR = 2'd1;
    localparam logic [1:0] CMD_RUN       = 2'd2;

    localparam logic CFG_TOWN_COUNT = 1'b0;
    localparam logic CFG_THRESHOLD  = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD_DIST,
        K_LOAD_TOUR,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  from_town;
        logic [5:0]  to_town;
        logic [15:0] distance;
        logic [5:0]  tour_position;
        logic [5:0]  town;
        logic        mutate;
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TI,
        ST_RD_TSI,
        ST_RD_TJ,
        ST_RD_TSJ,
        ST_RD_D0,
        ST_RD_D1,
        ST_RD_D2,
        ST_RD_D3,
        ST_CAP_D3,
        ST_SWAP_SI,
        ST_SWAP_SJ,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_bstate;

endpackage

>>> hw/rtl/tpsi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tpsi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tpsi_front.sv
// Front end: accepts input transfers, drops loads out of range and unused
// commands, decides mutation on a run and pushes an operation to the queue.
// Depends on tpsi_pkg.
module tpsi_front #(
    parameter int MAX_TOWNS = 64
) (
    input  logic             i_valid,
    output logic             o_ready,
    input  tpsi_pkg::t_in    i_item,
    input  logic [15:0]      i_threshold,
    input  logic             i_full,
    output logic             o_push,
    output tpsi_pkg::t_op    o_op
);

    logic keep;

    always_comb begin
        keep        = 1'b0;
        o_op.kind   = tpsi_pkg::K_RUN;
        case (i_item.command)
            tpsi_pkg::CMD_LOAD_DIST: begin
                o_op.kind = tpsi_pkg::K_LOAD_DIST;
                keep = (32'(i_item.from_town) < MAX_TOWNS) && (32'(i_item.to_town) < MAX_TOWNS);
            end
            tpsi_pkg::CMD_LOAD_TOUR: begin
                o_op.kind = tpsi_pkg::K_LOAD_TOUR;
                keep = 32'(i_item.tour_position) < MAX_TOWNS;
            end
            tpsi_pkg::CMD_RUN: begin
                o_op.kind = tpsi_pkg::K_RUN;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_op.from_town     = i_item.from_town;
        o_op.to_town       = i_item.to_town;
        o_op.distance      = i_item.distance;
        o_op.tour_position = i_item.tour_position;
        o_op.town          = i_item.town;
        o_op.mutate        = (i_threshold != 16'd0) && (i_item.random_fraction < i_threshold);
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

>>> hw/rtl/tpsi_queue.sv
// Short FIFO of decoded operations between front and back end.
// Depends on tpsi_pkg.
module tpsi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpsi_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output tpsi_pkg::t_op o_op,
    output logic          o_empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    tpsi_pkg::t_op r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

>>> hw/rtl/tpsi_back.sv
// Back end: carries out queued loads, the pair-swap pass and the tour readout.
// Holds the distance and tour RAMs and the output register.
// Depends on tpsi_pkg and tpsi_ram.
module tpsi_back #(
    parameter int MAX_TOWNS = 64,
    parameter int DIST_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [6:0]     i_town_count,
    input  logic           i_empty,
    input  tpsi_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tpsi_pkg::t_out o_out_data
);

    localparam int TOUR_CAP = (MAX_TOWNS < 64) ? MAX_TOWNS : 64;
    localparam int TPOS_W   = $clog2(TOUR_CAP);
    localparam int DDEPTH   = MAX_TOWNS * MAX_TOWNS;
    localparam int DADDR_W  = $clog2(DDEPTH);
    localparam logic [6:0] CAP7 = 7'(TOUR_CAP);

    function automatic logic [DADDR_W-1:0] dist_addr(input logic [5:0] a, input logic [5:0] b);
        logic [31:0] full;
        full = 32'(a) * 32'(MAX_TOWNS) + 32'(b);
        return full[DADDR_W-1:0];
    endfunction

    tpsi_pkg::t_bstate r_state, n_state;
    logic [TPOS_W-1:0] r_i, n_i;
    logic [TPOS_W-1:0] r_j, n_j;
    logic [TPOS_W-1:0] r_k, n_k;
    logic [TPOS_W-1:0] r_nm1, n_nm1;
    logic              r_mutate, n_mutate;
    logic [5:0]        r_ti, n_ti, r_tsi, n_tsi, r_tj, n_tj, r_tsj, n_tsj;
    logic [DIST_BITS-1:0] r_d0, n_d0, r_d1, n_d1, r_d2, n_d2, r_d3, n_d3;
    logic              r_dok, n_dok;
    logic              r_out_valid, n_out_valid;
    tpsi_pkg::t_out    r_out, n_out;

    logic [TPOS_W-1:0] si, sj;
    logic [5:0]        ra, rb;
    logic [6:0]        n_use;
    logic [TPOS_W-1:0] nm1_sat;
    logic              out_free, pair_done;
    logic [DIST_BITS:0] now_len, alt_len;
    logic [DIST_BITS-1:0] d_z;

    logic                 t_we;
    logic [TPOS_W-1:0]    t_waddr, t_raddr;
    logic [5:0]           t_wdata, t_rdata;
    logic                 d_we;
    logic [DIST_BITS-1:0] d_rdata;

    tpsi_ram #(.WIDTH(6), .DEPTH(TOUR_CAP)) u_tour_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    tpsi_ram #(.WIDTH(DIST_BITS), .DEPTH(DDEPTH)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (dist_addr(i_op.from_town, i_op.to_town)),
        .i_wdata (DIST_BITS'(i_op.distance)),
        .i_raddr (dist_addr(ra, rb)),
        .o_rdata (d_rdata)
    );

    assign si       = (r_i == r_nm1) ? '0 : r_i + TPOS_W'(1);
    assign sj       = (r_j == r_nm1) ? '0 : r_j + TPOS_W'(1);
    assign out_free = !r_out_valid || i_out_ready;
    // an out-of-range town reads every distance as zero
    assign d_z      = r_dok ? d_rdata : '0;
    assign now_len  = {1'b0, r_d0} + {1'b0, r_d1};
    assign alt_len  = {1'b0, r_d2} + {1'b0, r_d3};
    assign n_dok    = (32'(ra) < MAX_TOWNS) && (32'(rb) < MAX_TOWNS);

    always_comb begin
        if (i_town_count < 7'd2) begin
            n_use = 7'd2;
        end else if (i_town_count > CAP7) begin
            n_use = CAP7;
        end else begin
            n_use = i_town_count;
        end
        nm1_sat = TPOS_W'(n_use - 7'd1);
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_nm1       = r_nm1;
        n_mutate    = r_mutate;
        n_ti        = r_ti;
        n_tsi       = r_tsi;
        n_tj        = r_tj;
        n_tsj       = r_tsj;
        n_d0        = r_d0;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_d3        = r_d3;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;
        t_we        = 1'b0;
        t_waddr     = TPOS_W'(i_op.tour_position);
        t_wdata     = i_op.town;
        t_raddr     = r_k;
        d_we        = 1'b0;
        ra          = r_ti;
        rb          = r_tsi;
        pair_done   = 1'b0;

        case (r_state)
            tpsi_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_op.kind)
                        tpsi_pkg::K_LOAD_DIST: begin
                            d_we = 1'b1;
                        end
                        tpsi_pkg::K_LOAD_TOUR: begin
                            t_we = 1'b1;
                        end
                        tpsi_pkg::K_RUN: begin
                            n_mutate = i_op.mutate;
                            n_nm1    = nm1_sat;
                            n_i      = '0;
                            n_j      = '0;
                            n_k      = '0;
                            n_state  = i_op.mutate ? tpsi_pkg::ST_RD_TI : tpsi_pkg::ST_EMIT_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tpsi_pkg::ST_RD_TI: begin
                t_raddr = r_i;
                n_state = tpsi_pkg::ST_RD_TSI;
            end
            tpsi_pkg::ST_RD_TSI: begin
                t_raddr = si;
                n_ti    = t_rdata;
                n_state = tpsi_pkg::ST_RD_TJ;
            end
            tpsi_pkg::ST_RD_TJ: begin
                t_raddr = r_j;
                n_tsi   = t_rdata;
                n_state = tpsi_pkg::ST_RD_TSJ;
            end
            tpsi_pkg::ST_RD_TSJ: begin
                t_raddr = sj;
                n_tj    = t_rdata;
                n_state = tpsi_pkg::ST_RD_D0;
            end
            tpsi_pkg::ST_RD_D0: begin
                n_tsj   = t_rdata;
                ra      = r_ti;
                rb      = r_tsi;
                n_state = tpsi_pkg::ST_RD_D1;
            end
            tpsi_pkg::ST_RD_D1: begin
                n_d0    = d_z;
                ra      = r_tj;
                rb      = r_tsj;
                n_state = tpsi_pkg::ST_RD_D2;
            end
            tpsi_pkg::ST_RD_D2: begin
                n_d1    = d_z;
                ra      = r_ti;
                rb      = r_tsj;
                n_state = tpsi_pkg::ST_RD_D3;
            end
            tpsi_pkg::ST_RD_D3: begin
                n_d2    = d_z;
                ra      = r_tj;
                rb      = r_tsi;
                n_state = tpsi_pkg::ST_CAP_D3;
            end
            tpsi_pkg::ST_CAP_D3: begin
                n_d3    = d_z;
                n_state = tpsi_pkg::ST_SWAP_SI;
            end
            tpsi_pkg::ST_SWAP_SI: begin
                if (now_len > alt_len) begin
                    t_we    = 1'b1;
                    t_waddr = si;
                    t_wdata = r_tsj;
                    n_state = tpsi_pkg::ST_SWAP_SJ;
                end else begin
                    pair_done = 1'b1;
                end
            end
            tpsi_pkg::ST_SWAP_SJ: begin
                t_we      = 1'b1;
                t_waddr   = sj;
                t_wdata   = r_tsi;
                pair_done = 1'b1;
            end
            tpsi_pkg::ST_EMIT_RD: begin
                // issue the read only when the output register is free next cycle
                if (out_free) begin
                    t_raddr = r_k;
                    n_state = tpsi_pkg::ST_EMIT_LD;
                end
            end
            tpsi_pkg::ST_EMIT_LD: begin
                n_out_valid    = 1'b1;
                n_out.position = 6'(r_k);
                n_out.town_res = t_rdata;
                n_out.mutated  = r_mutate;
                n_out.last     = (r_k == r_nm1);
                if (r_k == r_nm1) begin
                    n_state = tpsi_pkg::ST_IDLE;
                end else begin
                    n_k     = r_k + TPOS_W'(1);
                    n_state = tpsi_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = tpsi_pkg::ST_IDLE;
            end
        endcase

        // advance the inner index, then the outer one; readout follows the last pair
        if (pair_done) begin
            if (r_j == r_nm1) begin
                n_j = '0;
                if (r_i == r_nm1) begin
                    n_i     = '0;
                    n_k     = '0;
                    n_state = tpsi_pkg::ST_EMIT_RD;
                end else begin
                    n_i     = r_i + TPOS_W'(1);
                    n_state = tpsi_pkg::ST_RD_TI;
                end
            end else begin
                n_j     = r_j + TPOS_W'(1);
                n_state = tpsi_pkg::ST_RD_TI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpsi_pkg::ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nm1    <= n_nm1;
        r_mutate <= n_mutate;
        r_ti     <= n_ti;
        r_tsi    <= n_tsi;
        r_tj     <= n_tj;
        r_tsj    <= n_tsj;
        r_d0     <= n_d0;
        r_d1     <= n_d1;
        r_d2     <= n_d2;
        r_d3     <= n_d3;
        r_dok    <= n_dok;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/tour_pair_swap_improvement.sv
// Tour pair-swap improvement block (top level).
// Depends on tpsi_pkg, tpsi_front, tpsi_queue and tpsi_back.
//
// Usage: the input channel carries commands. A distance load writes one matrix
// entry and a tour load one tour position; the back end carries out each load
// from idle, so loads stream at one transfer per cycle while no run is in
// progress. A run decides on mutation from random_fraction against
// mutate_threshold and, if it mutates, walks every position pair (i, j): four
// tour reads, four distance reads through the single read ports of the tour
// and distance RAMs, a compare and an optional two-write swap. The tour is then
// read out one position at a time on the output channel, the entry for position
// n-1 flagged last. A four-entry queue sits between the front end and the back
// end, so the input keeps taking transfers while a run is in progress until
// the queue fills. When the receiver stalls, the output register holds its
// transfer and readout pauses. Reset empties the queue, returns the back end to
// idle and sets town_count to 64 and the threshold to 0; the RAMs are not
// cleared and must be loaded before a run.
module tour_pair_swap_improvement #(
    parameter int MAX_TOWNS = 64,
    parameter int DIST_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tpsi_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tpsi_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);

    logic [6:0]    r_town_count;
    logic [15:0]   r_threshold;
    logic          q_full, q_empty, q_push, q_pop;
    tpsi_pkg::t_op push_op, pop_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_town_count <= 7'd64;
            r_threshold  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpsi_pkg::CFG_TOWN_COUNT: r_town_count <= i_cfg_data[6:0];
                tpsi_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tpsi_front #(.MAX_TOWNS(MAX_TOWNS)) u_front (
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_data),
        .i_threshold (r_threshold),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_op        (push_op)
    );

    tpsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (pop_op),
        .o_empty (q_empty)
    );

    tpsi_back #(.MAX_TOWNS(MAX_TOWNS), .DIST_BITS(DIST_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_town_count (r_town_count),
        .i_empty      (q_empty),
        .i_op         (pop_op),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the tour pair-swap improvement block.
// Drives load and run commands, predicts each emitted tour entry, checks it on the output.
// Depends on tpsi_pkg and tour_pair_swap_improvement.
module testbench;

    localparam int          N_TOWNS      = 64;
    localparam int          CLK_HALF     = 10;
    localparam int          SETTLE       = 40;
    localparam int          HOLD_CYCLES  = 800;
    localparam int          ITEM_GOAL    = 500;
    localparam longint      LIMIT_CYCLES = 1000000;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    tpsi_pkg::t_in in_data;
    logic          out_valid;
    logic          out_ready;
    tpsi_pkg::t_out out_data;
    logic          cfg_we;
    logic          cfg_idx;
    logic [15:0]   cfg_data;

    // predicted state of the block
    logic [15:0] dist_mem [N_TOWNS][N_TOWNS];
    logic [5:0]  tour_mem [N_TOWNS];
    logic [6:0]  town_count_reg;
    logic [15:0] threshold_reg;
    tpsi_pkg::t_out expected_tour [$];

    // stimulus planning state
    tpsi_pkg::t_in pending_cmds [$];
    bit          dist_known [N_TOWNS][N_TOWNS];
    bit          tour_known [N_TOWNS];
    logic [5:0]  plan_tour [N_TOWNS];
    int          items_queued;
    int          phase_no;
    int          failures;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_request = 1'b0;
    logic        rx_hold = 1'b0;

    tour_pair_swap_improvement u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int active_towns(logic [6:0] raw);
        if (raw < 7'd2) return 2;
        if (raw > 7'd64) return 64;
        return int'(raw);
    endfunction

    function automatic void improve_tour(int n);
        int          i;
        int          j;
        int          si;
        int          sj;
        logic [5:0]  ti;
        logic [5:0]  tsi;
        logic [5:0]  tj;
        logic [5:0]  tsj;
        logic [16:0] now_len;
        logic [16:0] alt_len;
        for (i = 0; i < n; i++) begin
            si = (i + 1) % n;
            for (j = 0; j < n; j++) begin
                sj = (j + 1) % n;
                ti = tour_mem[i];
                tsi = tour_mem[si];
                tj = tour_mem[j];
                tsj = tour_mem[sj];
                now_len = 17'(dist_mem[ti][tsi]) + 17'(dist_mem[tj][tsj]);
                alt_len = 17'(dist_mem[ti][tsj]) + 17'(dist_mem[tj][tsi]);
                if (now_len > alt_len) begin
                    tour_mem[si] = tsj;
                    tour_mem[sj] = tsi;
                end
            end
        end
    endfunction

    // Update the predicted state for one accepted command; a run queues the whole tour.
    function automatic void apply_command(tpsi_pkg::t_in cmd);
        int   n;
        int   k;
        logic mutate;
        tpsi_pkg::t_out entry;
        case (cmd.command)
            tpsi_pkg::CMD_LOAD_DIST: dist_mem[cmd.from_town][cmd.to_town] = cmd.distance;
            tpsi_pkg::CMD_LOAD_TOUR: tour_mem[cmd.tour_position] = cmd.town;
            tpsi_pkg::CMD_RUN: begin
                n = active_towns(town_count_reg);
                mutate = (threshold_reg != 16'd0) && (cmd.random_fraction < threshold_reg);
                if (mutate) improve_tour(n);
                for (k = 0; k < n; k++) begin
                    entry.position = 6'(k);
                    entry.town_res = tour_mem[k];
                    entry.mutated  = mutate;
                    entry.last     = (k == n - 1);
                    expected_tour.push_back(entry);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Input side: offer the next pending command, hold it until the transfer.
    always @(posedge clk) begin : drive_commands
        logic fire;
        logic go;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && in_ready;
            if (fire) apply_command(in_data);
            if (!in_valid || fire) begin
                go = (pending_cmds.size() != 0) && ($urandom_range(99, 0) >= tx_idle_pct);
                if (go) in_data <= pending_cmds.pop_front();
                in_valid <= go;
            end
        end
    end

    // Output side: check each transfer against the oldest expected tour entry.
    always @(posedge clk) begin : watch_tour
        tpsi_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tour.size() == 0) begin
                $error("unexpected result: position %0d town_res %0d",
                       out_data.position, out_data.town_res);
                failures++;
            end else begin
                want = expected_tour.pop_front();
                check_field("position", want.position, out_data.position);
                check_field("town_res", want.town_res, out_data.town_res);
                check_field("mutated", 6'(want.mutated), 6'(out_data.mutated));
                check_field("last", 6'(want.last), 6'(out_data.last));
            end
        end
        out_ready <= rst_n && !rx_hold && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Long receiver hold-off so that the internal queue fills and the input stalls.
    initial begin
        wait (hold_request);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || in_valid || expected_tour.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tpsi_pkg::CFG_TOWN_COUNT) town_count_reg = value[6:0];
        else threshold_reg = value;
    endtask

    function automatic tpsi_pkg::t_in make_cmd(logic [1:0] code);
        logic [63:0]   raw;
        tpsi_pkg::t_in cmd;
        raw = {$urandom, $urandom};
        cmd = raw[$bits(tpsi_pkg::t_in)-1:0];
        cmd.command = code;
        return cmd;
    endfunction

    function automatic void push_cmd(tpsi_pkg::t_in cmd);
        pending_cmds.push_back(cmd);
        if (cmd.command != CMD_UNUSED) items_queued++;
        if (cmd.command == tpsi_pkg::CMD_LOAD_TOUR) begin
            plan_tour[cmd.tour_position] = cmd.town;
            tour_known[cmd.tour_position] = 1'b1;
        end
        if (cmd.command == tpsi_pkg::CMD_LOAD_DIST)
            dist_known[cmd.from_town][cmd.to_town] = 1'b1;
    endfunction

    function automatic void load_tour(logic [5:0] pos, logic [5:0] town);
        tpsi_pkg::t_in cmd;
        cmd = make_cmd(tpsi_pkg::CMD_LOAD_TOUR);
        cmd.tour_position = pos;
        cmd.town = town;
        push_cmd(cmd);
    endfunction

    function automatic void load_dist(logic [5:0] a, logic [5:0] b, logic [15:0] value);
        tpsi_pkg::t_in cmd;
        cmd = make_cmd(tpsi_pkg::CMD_LOAD_DIST);
        cmd.from_town = a;
        cmd.to_town = b;
        cmd.distance = value;
        push_cmd(cmd);
    endfunction

    function automatic void launch_run(logic [15:0] fraction);
        tpsi_pkg::t_in cmd;
        cmd = make_cmd(tpsi_pkg::CMD_RUN);
        cmd.random_fraction = fraction;
        push_cmd(cmd);
    endfunction

    // Small values give ties and frequent swaps; extremes stress the sums.
    function automatic logic [15:0] pick_distance();
        case ($urandom_range(9, 0))
            0:          return 16'd0;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(20, 0));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_fraction(logic [15:0] thresh);
        case ($urandom_range(5, 0))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return thresh;
            3:       return thresh - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Load every matrix entry that a pass over positions 0..n-1 can read.
    function automatic void cover_distances(int n);
        int p;
        int q;
        for (p = 0; p < n; p++)
            for (q = 0; q < n; q++)
                if (!dist_known[plan_tour[p]][plan_tour[q]])
                    load_dist(plan_tour[p], plan_tour[q], pick_distance());
    endfunction

    task automatic play_phase(logic [6:0] raw_count, logic [15:0] thresh, int rounds,
                              bit squeeze);
        int         n;
        int         p;
        int         r;
        int         extra;
        int         palette_size;
        logic [5:0] palette [6];
        logic [8:0] junk;
        wait_quiet();
        case (phase_no % 4)
            0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            1:       begin tx_idle_pct = 72; rx_idle_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_idle_pct = 72; end
            default: begin tx_idle_pct = 24; rx_idle_pct = 24; end
        endcase
        phase_no++;
        junk = 9'($urandom);
        write_reg(tpsi_pkg::CFG_TOWN_COUNT, {junk, raw_count});
        write_reg(tpsi_pkg::CFG_THRESHOLD, thresh);
        n = active_towns(raw_count);
        for (p = 0; p < N_TOWNS; p++) plan_tour[p] = tour_mem[p];
        // large tours draw from a few towns to keep the matrix load short
        palette_size = (n > 16) ? $urandom_range(6, 1) : 0;
        for (p = 0; p < palette_size; p++) palette[p] = 6'($urandom);
        if (squeeze) hold_request = 1'b1;
        for (p = 0; p < n; p++) begin
            if (palette_size != 0)
                load_tour(6'(p), palette[$urandom_range(palette_size - 1, 0)]);
            else if (!tour_known[p] || $urandom_range(2, 0) == 0)
                load_tour(6'(p), 6'($urandom));
        end
        extra = $urandom_range(2, 0);
        for (p = 0; p < extra; p++) load_tour(6'($urandom), 6'($urandom));
        // runs permute positions 0..n-1, so later rounds only touch distances
        for (r = 0; r < rounds; r++) begin
            if (r != 0) begin
                extra = $urandom_range(3, 0);
                for (p = 0; p < extra; p++)
                    load_dist(plan_tour[$urandom_range(n - 1, 0)],
                              plan_tour[$urandom_range(n - 1, 0)], pick_distance());
            end
            if ($urandom_range(3, 0) == 0)
                load_dist(6'($urandom), 6'($urandom), pick_distance());
            cover_distances(n);
            if ($urandom_range(7, 0) == 0) push_cmd(make_cmd(CMD_UNUSED));
            launch_run(pick_fraction(thresh));
        end
        if (squeeze)
            for (p = 0; p < 12; p++) load_dist(6'($urandom), 6'($urandom), pick_distance());
    endtask

    initial begin : stimulus
        logic [6:0]  raw;
        logic [15:0] thresh;
        int          k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = tpsi_pkg::CFG_TOWN_COUNT;
        cfg_data = '0;
        town_count_reg = 7'd64;
        threshold_reg = 16'd0;
        failures = 0;
        items_queued = 0;
        phase_no = 1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Two towns at the index extremes; the edge sum overflows 16 bits and forces a swap.
        write_reg(tpsi_pkg::CFG_TOWN_COUNT, 16'd2);
        write_reg(tpsi_pkg::CFG_THRESHOLD, 16'hFFFF);
        load_tour(6'd0, 6'd0);
        load_tour(6'd1, 6'd63);
        load_dist(6'd0, 6'd0, 16'd0);
        load_dist(6'd0, 6'd63, 16'hFFFF);
        load_dist(6'd63, 6'd0, 16'd1);
        load_dist(6'd63, 6'd63, 16'd0);
        launch_run(16'd0);
        launch_run(16'hFFFF);
        push_cmd(make_cmd(CMD_UNUSED));
        wait_quiet();

        // Three towns with the smallest threshold: fraction zero mutates, one does not.
        write_reg(tpsi_pkg::CFG_TOWN_COUNT, 16'd3);
        write_reg(tpsi_pkg::CFG_THRESHOLD, 16'd1);
        load_tour(6'd0, 6'd5);
        load_tour(6'd1, 6'd6);
        load_tour(6'd2, 6'd7);
        cover_distances(3);
        launch_run(16'd0);
        launch_run(16'd1);

        // keep going at least through the hold-off phase
        while (items_queued < ITEM_GOAL || phase_no <= 4) begin
            k = $urandom_range(19, 0);
            case ($urandom_range(5, 0))
                0:       thresh = 16'd0;
                1:       thresh = 16'hFFFF;
                2:       thresh = 16'd1;
                default: thresh = 16'($urandom);
            endcase
            if (phase_no == 4) begin
                play_phase(7'd4, 16'hFFFF, 1, 1'b1);
            end else if (phase_no == 6 || phase_no == 12) begin
                raw = (phase_no == 6) ? 7'd127 : 7'd64;
                play_phase(raw, 16'hFFFF, 1, 1'b0);
            end else begin
                if (k < 3) raw = 7'($urandom_range(1, 0));
                else if (k < 6) raw = 7'($urandom_range(16, 9));
                else raw = 7'($urandom_range(8, 2));
                play_phase(raw, thresh, $urandom_range(3, 1), 1'b0);
            end
        end

        wait_quiet();
        if (failures == 0 && expected_tour.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tpsi_pkg.sv
hw/rtl/tpsi_ram.sv
hw/rtl/tpsi_front.sv
hw/rtl/tpsi_queue.sv
hw/rtl/tpsi_back.sv
hw/rtl/tour_pair_swap_improvement.sv
tb/testbench.sv
